### hw/rtl/lmdv_pkg.sv
`timescale 1ns / 1ps

package lmdv_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int CHAN_W     = 1;
  localparam int PHASE_W    = 32;
  localparam int STEP_W     = 24;
  localparam int DEPTH_W    = 12;
  localparam int SINE_W     = 16;
  localparam int FRAC_W     = 16;
  localparam int DINT_W     = 5;
  localparam int DELAY_W    = 21;
  localparam int DEPTH_FRAC = 8;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 24;

  // Shared multiplier: signed 25 x signed 18
  localparam int MUL_A_W = 25;
  localparam int MUL_B_W = 18;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH      = CFG_IDX_W'(1);

  localparam logic [STEP_W-1:0]  PHASE_STEP_RST = STEP_W'(89478);
  localparam logic [DEPTH_W-1:0] DEPTH_RST      = DEPTH_W'(0);

  // Fixed part of the delay: five samples in Q16
  localparam logic [DELAY_W-1:0] BASE_DELAY = DELAY_W'(5 * 65536);

  // Odd sine polynomial in Q30
  localparam longint Q30_ONE = 64'sd1073741824;
  localparam longint SIN_C1  = 64'sd1686629713;
  localparam longint SIN_C3  = -64'sd693598669;
  localparam longint SIN_C5  = 64'sd85569305;
  localparam longint SIN_C7  = -64'sd5026995;
  localparam longint SIN_C9  = 64'sd172272;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_SINE,
    ST_DEPTH,
    ST_POS,
    ST_RDA,
    ST_RDB,
    ST_MULB,
    ST_DONE
  } state_t;

endpackage

### hw/rtl/lmdv_if.sv
`timescale 1ns / 1ps

interface lmdv_in_if;
  import lmdv_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [CHAN_W-1:0]          channel;
  logic signed [SAMPLE_W-1:0] sample_in;
  modport source (output valid, output channel, output sample_in, input ready);
  modport sink (input valid, input channel, input sample_in, output ready);
endinterface

interface lmdv_out_if;
  import lmdv_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [CHAN_W-1:0]          channel_out;
  logic signed [SAMPLE_W-1:0] sample_out;
  modport source (output valid, output channel_out, output sample_out, input ready);
  modport sink (input valid, input channel_out, input sample_out, output ready);
endinterface

interface lmdv_cfg_if;
  import lmdv_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### hw/rtl/lmdv_sine_rom.sv
`timescale 1ns / 1ps

module lmdv_sine_rom #(
  parameter int SINE_TABLE_SIZE = 1024
) (
  input  logic                                 clk,
  input  logic [$clog2(SINE_TABLE_SIZE)-1:0]   idx,
  output logic signed [lmdv_pkg::SINE_W-1:0]   sine_r
);
  import lmdv_pkg::*;

  // Quarter-wave folded polynomial, rounded to Q15 and clamped
  function automatic logic signed [SINE_W-1:0] sine_value(input longint p);
    longint     x;
    longint     x2;
    longint     t;
    longint     y;
    logic [1:0] quad;
    quad = p[31:30];
    x    = p & 64'sh3FFFFFFF;
    if (quad[0]) begin
      x = Q30_ONE - x;
    end
    x2 = (x * x) >>> 30;
    t  = SIN_C9;
    t  = SIN_C7 + ((t * x2) >>> 30);
    t  = SIN_C5 + ((t * x2) >>> 30);
    t  = SIN_C3 + ((t * x2) >>> 30);
    t  = SIN_C1 + ((t * x2) >>> 30);
    y  = (t * x) >>> 30;
    y  = (y + 64'sd16384) >>> 15;
    if (y < 0) begin
      y = 0;
    end
    if (y > 32767) begin
      y = 32767;
    end
    return quad[1] ? -SINE_W'(y) : SINE_W'(y);
  endfunction

  logic signed [SINE_W-1:0] table_w [SINE_TABLE_SIZE];

  for (genvar k = 0; k < SINE_TABLE_SIZE; k++) begin : g_entry
    localparam longint P = (longint'(k) << 32) / SINE_TABLE_SIZE;
    assign table_w[k] = sine_value(P);
  end

  always_ff @(posedge clk) begin
    sine_r <= table_w[idx];
  end

endmodule

### hw/rtl/lfo_modulated_delay_vibrato.sv
`timescale 1ns / 1ps

// Channel  Dir  Handshake        Payload
// in_ch    in   valid / ready    channel, sample_in
// out_ch   out  valid / ready    channel_out, sample_out
// cfg_ch   in   valid / ready    index, data (ready always high)
//
// The sequencer steps each sample request through one shared 25x18 multiplier
// and a dual-port delay memory, and takes no new request until the result is
// stored. A request for a channel outside the configured range returns a zero
// sample. After reset a clearing pass zeroes the delay memory, with in_ch not
// ready. A stalled result holds the sequencer in its last step.
module lfo_modulated_delay_vibrato #(
  parameter int MAX_DELAY       = 32,
  parameter int CHANNELS        = 2,
  parameter int SINE_TABLE_SIZE = 1024
) (
  input logic       clk,
  input logic       rst_n,
  lmdv_in_if.sink   in_ch,
  lmdv_out_if.source out_ch,
  lmdv_cfg_if.sink  cfg_ch
);
  import lmdv_pkg::*;

  localparam int WP_W      = $clog2(MAX_DELAY);
  localparam int POS_W     = WP_W + 2;
  localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int MEM_DEPTH = CHANNELS * MAX_DELAY;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int TIDX_W    = $clog2(SINE_TABLE_SIZE);
  localparam int TPROD_W   = PHASE_W + TIDX_W;
  localparam int ACC_W     = PROD_W;

  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(32768);
  localparam logic signed [ACC_W-1:0] SMP_MAX    = ACC_W'(8388607);
  localparam logic signed [ACC_W-1:0] SMP_MIN    = -ACC_W'(8388608);

  function automatic logic [ADDR_W-1:0] mem_addr(input logic [CH_W-1:0] ch,
                                                input logic [WP_W-1:0] pos);
    return ADDR_W'(ch) * ADDR_W'(MAX_DELAY) + ADDR_W'(pos);
  endfunction

  state_t state_r, state_nxt;

  logic [ADDR_W-1:0]          clr_cnt_r;
  logic [WP_W-1:0]            wp_r [CHANNELS];
  logic [PHASE_W-1:0]         phase_r [CHANNELS];
  logic [STEP_W-1:0]          phase_step_r;
  logic [DEPTH_W-1:0]         depth_r;
  logic [CHAN_W-1:0]          ch_r;
  logic signed [SAMPLE_W-1:0] smp_r;
  logic                       bypass_r;
  logic [TIDX_W-1:0]          tidx_r;
  logic [DELAY_W-1:0]         delay_r;
  logic [WP_W-1:0]            idx_r;
  logic [WP_W-1:0]            nxt_r;
  logic [FRAC_W-1:0]          frac_r;
  logic signed [SAMPLE_W-1:0] rd_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic                       out_valid_r;
  logic [CHAN_W-1:0]          out_ch_r;
  logic signed [SAMPLE_W-1:0] out_smp_r;

  logic signed [SAMPLE_W-1:0] mem [MEM_DEPTH];

  logic                       in_fire;
  logic                       out_free;
  logic                       done_fire;
  logic                       mem_we;
  logic [ADDR_W-1:0]          mem_waddr;
  logic [ADDR_W-1:0]          mem_raddr;
  logic signed [SAMPLE_W-1:0] mem_wdata;
  logic [CH_W-1:0]            chi;
  logic [WP_W-1:0]            wp_cur;
  logic [TPROD_W-1:0]         tprod;
  logic signed [SINE_W-1:0]   sine_r;
  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [PROD_W-1:0]   prod;
  logic signed [POS_W-1:0]    pos0, pos1, pos2;
  logic [WP_W-1:0]            idx_w;
  logic signed [ACC_W-1:0]    rnd;
  logic signed [SAMPLE_W-1:0] smp_res;

  assign chi    = CH_W'(ch_r);
  assign wp_cur = wp_r[chi];

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_fire      = in_ch.valid && in_ch.ready;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.channel_out = out_ch_r;
  assign out_ch.sample_out  = out_smp_r;

  assign out_free  = !out_valid_r || out_ch.ready;
  assign done_fire = (state_r == ST_DONE) && out_free;

  lmdv_sine_rom #(
    .SINE_TABLE_SIZE(SINE_TABLE_SIZE)
  ) u_sine_rom (
    .clk   (clk),
    .idx   (tidx_r),
    .sine_r(sine_r)
  );

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    mem_we    = 1'b0;
    mem_waddr = clr_cnt_r;
    mem_wdata = '0;
    mem_raddr = mem_addr(chi, idx_r);
    case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
        if (clr_cnt_r == ADDR_W'(MEM_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = (int'(in_ch.channel) >= CHANNELS) ? ST_DONE : ST_WRITE;
        end
      end
      ST_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = mem_addr(chi, wp_cur);
        mem_wdata = smp_r;
        state_nxt = ST_SINE;
      end
      ST_SINE:  state_nxt = ST_DEPTH;
      ST_DEPTH: state_nxt = ST_POS;
      ST_POS:   state_nxt = ST_RDA;
      ST_RDA:   state_nxt = ST_RDB;
      ST_RDB: begin
        mem_raddr = mem_addr(chi, nxt_r);
        state_nxt = ST_MULB;
      end
      ST_MULB:  state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_DEPTH: begin
        mul_a = MUL_A_W'(depth_r);
        mul_b = MUL_B_W'({~sine_r[SINE_W-1], sine_r[SINE_W-2:0]});
      end
      ST_RDB: begin
        mul_a = MUL_A_W'(rd_r);
        mul_b = MUL_B_W'((FRAC_W + 1)'(65536) - (FRAC_W + 1)'(frac_r));
      end
      ST_MULB: begin
        mul_a = MUL_A_W'(rd_r);
        mul_b = MUL_B_W'(frac_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Read position: integer part behind the write pointer, wrapped into the line
  always_comb begin
    pos0 = POS_W'(wp_cur) - POS_W'(delay_r[FRAC_W +: DINT_W])
         - POS_W'(|delay_r[FRAC_W-1:0]);
    pos1 = pos0[POS_W-1] ? pos0 + POS_W'(MAX_DELAY) : pos0;
    pos2 = pos1[POS_W-1] ? pos1 + POS_W'(MAX_DELAY) : pos1;
    idx_w = pos2[WP_W-1:0];
  end

  assign tprod = TPROD_W'(phase_r[chi]) * TPROD_W'(SINE_TABLE_SIZE);

  // Round half up, clamp to Q1.23
  always_comb begin
    rnd = (acc_r + ROUND_HALF) >>> FRAC_W;
    if (rnd > SMP_MAX) begin
      smp_res = SAMPLE_W'(SMP_MAX);
    end else if (rnd < SMP_MIN) begin
      smp_res = SAMPLE_W'(SMP_MIN);
    end else begin
      smp_res = SAMPLE_W'(rnd);
    end
  end

  // Delay memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (state_r == ST_CLEAR) begin
      clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
    end
  end

  // Datapath steps
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          ch_r     <= in_ch.channel;
          smp_r    <= in_ch.sample_in;
          bypass_r <= (int'(in_ch.channel) >= CHANNELS);
        end
      end
      ST_WRITE: tidx_r  <= tprod[PHASE_W +: TIDX_W];
      ST_DEPTH: delay_r <= BASE_DELAY + DELAY_W'(prod[DEPTH_FRAC +: (DELAY_W - 1)]);
      ST_POS: begin
        idx_r  <= idx_w;
        nxt_r  <= (idx_w == WP_W'(MAX_DELAY - 1)) ? '0 : idx_w + WP_W'(1);
        frac_r <= FRAC_W'(0) - delay_r[FRAC_W-1:0];
      end
      ST_RDB:  acc_r <= prod;
      ST_MULB: acc_r <= acc_r + prod;
      default: ;
    endcase
  end

  // Per-channel pointers advance only once the result is loaded into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        wp_r[c]    <= '0;
        phase_r[c] <= '0;
      end
    end else if (done_fire && !bypass_r) begin
      wp_r[chi]    <= (wp_cur == WP_W'(MAX_DELAY - 1)) ? '0 : wp_cur + WP_W'(1);
      phase_r[chi] <= phase_r[chi] + PHASE_W'(phase_step_r);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_fire) begin
      out_ch_r  <= ch_r;
      out_smp_r <= bypass_r ? '0 : smp_res;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r <= PHASE_STEP_RST;
      depth_r      <= DEPTH_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_PHASE_STEP: phase_step_r <= cfg_ch.data[STEP_W-1:0];
        CFG_DEPTH:      depth_r      <= cfg_ch.data[DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

### test/tb.sv
`timescale 1ns / 1ps

module tb;
  import lmdv_pkg::*;

  localparam int LINE_LEN    = 32;
  localparam int CHAN_CNT    = 2;
  localparam int SINE_SIZE   = 1024;
  localparam int RAND_PHASES = 16;
  localparam int PHASE_ITEMS = 119;

  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SPARE = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_SPARE  = '1;

  localparam longint POLY_ONE = 64'sd1073741824;
  localparam longint POLY_C1  = 64'sd1686629713;
  localparam longint POLY_C3  = -64'sd693598669;
  localparam longint POLY_C5  = 64'sd85569305;
  localparam longint POLY_C7  = -64'sd5026995;
  localparam longint POLY_C9  = 64'sd172272;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idling_t;

  typedef struct packed {
    logic [CHAN_W-1:0]          ch;
    logic signed [SAMPLE_W-1:0] smp;
  } audio_word_t;

  logic clk = 1'b0;
  logic rst_n;

  lmdv_in_if  in_ch ();
  lmdv_out_if out_ch ();
  lmdv_cfg_if cfg_ch ();

  lfo_modulated_delay_vibrato #(
    .MAX_DELAY(LINE_LEN),
    .CHANNELS(CHAN_CNT),
    .SINE_TABLE_SIZE(SINE_SIZE)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predictor state: per-channel delay lines, write pointers and LFO phases
  logic signed [SAMPLE_W-1:0] line_mem [CHAN_CNT][LINE_LEN];
  logic [DINT_W-1:0]          wr_pos [CHAN_CNT];
  logic [PHASE_W-1:0]         lfo_acc [CHAN_CNT];
  logic [STEP_W-1:0]          step_reg;
  logic [DEPTH_W-1:0]         depth_reg;
  int                         lfo_sine_tab [SINE_SIZE];

  audio_word_t stim_q [$];
  audio_word_t vibrato_q [$];

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int          samples_queued;
  int          samples_taken;
  int          results_checked;
  int          cfg_writes;
  int          fail_count;
  bit          in_taken;

  function automatic int sine_value(input logic [PHASE_W-1:0] p);
    longint x, x2, t, y;
    x = longint'({2'b00, p[29:0]});
    // fold the odd quadrants back onto the rising quarter
    if (p[30])
      x = POLY_ONE - x;
    x2 = (x * x) >>> 30;
    t = POLY_C9;
    t = POLY_C7 + ((t * x2) >>> 30);
    t = POLY_C5 + ((t * x2) >>> 30);
    t = POLY_C3 + ((t * x2) >>> 30);
    t = POLY_C1 + ((t * x2) >>> 30);
    y = (t * x) >>> 30;
    y = (y + 16384) >>> 15;
    if (y < 0)
      y = 0;
    if (y > 32767)
      y = 32767;
    return p[31] ? -int'(y) : int'(y);
  endfunction

  function automatic audio_word_t vibrato_step(input audio_word_t req);
    audio_word_t        res;
    logic [DINT_W-1:0]  wp, idx, nxt;
    logic [DELAY_W-1:0] pos;
    longint             dep, wpl, dly, fr, acc;
    wp = wr_pos[req.ch];
    line_mem[req.ch][wp] = req.smp;
    dep = depth_reg;
    dly = 5 * 65536 + ((dep * (lfo_sine_tab[lfo_acc[req.ch][31:22]] + 32768)) >>> 8);
    wpl = wp;
    // wrap the read position onto the line: the line is a power of two long
    pos = DELAY_W'(wpl * 65536 - dly);
    idx = pos[DELAY_W-1:FRAC_W];
    nxt = idx + 1'b1;
    fr = pos[FRAC_W-1:0];
    acc = longint'(line_mem[req.ch][idx]) * (65536 - fr)
        + longint'(line_mem[req.ch][nxt]) * fr;
    acc = (acc + 32768) >>> 16;
    if (acc > 8388607)
      acc = 8388607;
    if (acc < -8388608)
      acc = -8388608;
    res.ch = req.ch;
    res.smp = acc[SAMPLE_W-1:0];
    wr_pos[req.ch] = wp + 1'b1;
    lfo_acc[req.ch] = lfo_acc[req.ch] + step_reg;
    return res;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int v;
    case ($urandom_range(7))
      0: v = 8388607;
      1: v = -8388608;
      2: v = int'($urandom_range(511)) - 256;
      default: v = int'($urandom);
    endcase
    return v[SAMPLE_W-1:0];
  endfunction

  task automatic set_idling(input idling_t mode);
    send_idle_pct  = (mode == IDLE_SEND || mode == IDLE_RECV) ? 0 : 0;
    recv_stall_pct = 0;
    case (mode)
      IDLE_SEND: send_idle_pct = 73;
      IDLE_RECV: recv_stall_pct = 73;
      IDLE_BOTH: begin
        send_idle_pct  = 22;
        recv_stall_pct = 22;
      end
      default: ;
    endcase
  endtask

  task automatic queue_sample(input logic [CHAN_W-1:0] ch, input logic signed [SAMPLE_W-1:0] smp);
    audio_word_t req;
    req.ch = ch;
    req.smp = smp;
    stim_q.push_back(req);
    samples_queued++;
  endtask

  // Hold until every request has been taken and every result checked
  task automatic wait_drained();
    do @(negedge clk);
    while (samples_taken != samples_queued || vibrato_q.size() != 0);
    repeat (12) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    int start;
    start = cfg_writes;
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(negedge clk);
    while (cfg_writes == start);
    cfg_ch.valid <= 1'b0;
  endtask

  always @(negedge clk) begin : drive
    audio_word_t req;
    if (rst_n) begin
      if (!in_ch.valid || in_taken) begin
        if (stim_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          req = stim_q.pop_front();
          in_ch.valid     <= 1'b1;
          in_ch.channel   <= req.ch;
          in_ch.sample_in <= req.smp;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : watch
    audio_word_t req, got, want;
    in_taken = 1'b0;
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_PHASE_STEP: step_reg = cfg_ch.data[STEP_W-1:0];
          CFG_DEPTH:      depth_reg = cfg_ch.data[DEPTH_W-1:0];
          default: ;
        endcase
        cfg_writes++;
      end
      in_taken = in_ch.valid && in_ch.ready;
      if (in_taken) begin
        req.ch = in_ch.channel;
        req.smp = in_ch.sample_in;
        vibrato_q.push_back(vibrato_step(req));
        samples_taken++;
      end
      if (out_ch.valid && out_ch.ready) begin
        got.ch = out_ch.channel_out;
        got.smp = out_ch.sample_out;
        if (vibrato_q.size() == 0) begin
          $display("%0t: unexpected result, channel %0d sample %0d", $time, got.ch, got.smp);
          fail_count++;
        end else begin
          want = vibrato_q.pop_front();
          if (got.ch != want.ch) begin
            $display("%0t: channel_out expected %0d, got %0d", $time, want.ch, got.ch);
            fail_count++;
          end
          if (got.smp !== want.smp) begin
            $display("%0t: sample_out expected %0d, got %0d", $time, want.smp, got.smp);
            fail_count++;
          end
          results_checked++;
        end
      end
    end
  end

  initial begin : main
    logic [CHAN_W-1:0]     cur_ch;
    logic [STEP_W-1:0]     new_step;
    logic [DEPTH_W-1:0]    new_depth;
    logic [CFG_IDX_W-1:0]  spare_idx;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.channel = '0;
    in_ch.sample_in = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    for (int c = 0; c < CHAN_CNT; c++) begin
      for (int i = 0; i < LINE_LEN; i++)
        line_mem[c][i] = '0;
      wr_pos[c] = '0;
      lfo_acc[c] = '0;
    end
    step_reg = PHASE_STEP_RST;
    depth_reg = DEPTH_RST;
    for (int k = 0; k < SINE_SIZE; k++)
      lfo_sine_tab[k] = sine_value({k[9:0], 22'd0});
    set_idling(IDLE_NONE);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings, no modulation: each channel echoes its input five requests back
    queue_sample(1'b0, 24'sh7FFFFF);
    queue_sample(1'b1, -24'sh800000);
    queue_sample(1'b0, -24'sh800000);
    queue_sample(1'b1, 24'sh7FFFFF);
    queue_sample(1'b0, 24'sh000000);
    queue_sample(1'b0, -24'sh000001);
    queue_sample(1'b1, 24'sh000001);
    queue_sample(1'b0, 24'sh555555);
    queue_sample(1'b1, 24'shAAAAAA);
    queue_sample(1'b0, 24'sh000001);
    queue_sample(1'b0, 24'sh7FFFFF);
    queue_sample(1'b1, 24'sh123456);
    wait_drained();

    // Depth above range and fastest LFO: read wraps far behind the write pointer
    write_reg(CFG_PHASE_STEP, 24'hFFFFFF);
    write_reg(CFG_DEPTH, 24'h000FFF);
    for (int i = 0; i < 6; i++)
      queue_sample(i[0], i[1] ? 24'sh7FFFFF : -24'sh800000);
    wait_drained();

    // Full depth with the LFO frozen; drop the upper data bits of the depth write
    write_reg(CFG_PHASE_STEP, 24'h000000);
    write_reg(CFG_DEPTH, 24'hABC800);
    write_reg(CFG_FIRST_SPARE, 24'hFFFFFF);
    for (int i = 0; i < 6; i++)
      queue_sample(i[1], pick_sample());
    wait_drained();

    cur_ch = CHAN_W'($urandom_range(1));
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case ($urandom_range(3))
        0: new_step = '0;
        1: new_step = '1;
        2: new_step = STEP_W'($urandom);
        default: new_step = STEP_W'($urandom_range(65535));
      endcase
      case ($urandom_range(4))
        0: new_depth = '0;
        1: new_depth = DEPTH_W'(2048);
        2: new_depth = '1;
        3: new_depth = DEPTH_W'($urandom_range(2048));
        default: new_depth = DEPTH_W'($urandom_range(4095));
      endcase
      if ($urandom_range(3) == 0) begin
        spare_idx = CFG_IDX_W'($urandom_range(CFG_LAST_SPARE, CFG_FIRST_SPARE));
        write_reg(spare_idx, CFG_DATA_W'($urandom));
      end
      write_reg(CFG_PHASE_STEP, new_step);
      write_reg(CFG_DEPTH, {12'($urandom), new_depth});
      set_idling(idling_t'(ph % 4));
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(3) == 0)
          cur_ch = ~cur_ch;
        queue_sample(cur_ch, pick_sample());
      end
      wait_drained();
    end

    $display("%0d samples sent across %0d settings, %0d results checked",
             samples_taken, RAND_PHASES + 3, results_checked);
    $display("%0d register writes, unused indexes among them", cfg_writes);
    if (fail_count == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

  initial begin : watchdog
    #20000000;
    $display("timeout: %0d of %0d samples taken, %0d results pending",
             samples_taken, samples_queued, vibrato_q.size());
    $display("tb NOT OK");
    $finish;
  end

endmodule
